>>> sv/sbmq_pkg.sv
// shared constants and controller/datapath interface types for the shared buffer multi queue
`default_nettype none
package sbmq_pkg;

    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    localparam int IO_W   = 32;
    localparam int EXT_W  = 64;
    localparam int QIN_W  = 2;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QA_W   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QX_W   = (QA_W > QIN_W) ? QA_W : QIN_W;

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOTS);

    localparam logic       KIND_ENQ = 1'b0;
    localparam logic       KIND_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic take_in;
        logic sel_live;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> sv/shared_buffer_multi_queue_unit.sv
// top level of the shared buffer multi queue
`default_nettype none
// Several FIFO queues kept as linked lists in one shared slot memory, with a
// free list of unused slots. A request is an enqueue or a dequeue on one
// queue and gives exactly one result: status ok, overflow (no free slot or
// unknown queue) or underflow (empty or unknown queue, data all ones). Each
// request steps through accept, pointer lookup in the registered-read
// head and tail tables, then slot link/word read and commit; the commit
// waits while the previous result is still held on the output. A new
// request is taken in the cycle after the commit, while that result waits.
module shared_buffer_multi_queue_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // data_in
    input  wire logic [2:0]  s_axis_tuser,   // kind, queue_id
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // data_out
    output logic [1:0]       m_axis_tuser    // status
);
    import sbmq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sbmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbmq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (s_axis_tuser[0]),
        .i_queue_id  (s_axis_tuser[2:1]),
        .i_data_in   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_data_out  (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> sv/sbmq_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/sbmq_ctrl.sv
// sequencer for accept, pointer lookup and commit of one request
`default_nettype none
module sbmq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sbmq_pkg::t_sts i_sts,
    output sbmq_pkg::t_cmd     o_cmd
);
    import sbmq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PTR  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.take_in  = 1'b0;
        o_cmd.sel_live = 1'b0;
        o_cmd.commit   = 1'b0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.sel_live = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_PTR;
                end
            end
            S_PTR: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> sv/sbmq_dp.sv
// slot, link and pointer storage with free list and result register
`default_nettype none
module sbmq_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sbmq_pkg::t_cmd              i_cmd,
    output sbmq_pkg::t_sts                   o_sts,
    input  wire logic                        i_kind,
    input  wire logic [sbmq_pkg::QIN_W-1:0]  i_queue_id,
    input  wire logic [sbmq_pkg::IO_W-1:0]   i_data_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic [sbmq_pkg::IO_W-1:0]        o_data_out
);
    import sbmq_pkg::*;

    logic              r_kind;
    logic [QIN_W-1:0]  r_q;
    logic [IO_W-1:0]   r_data;

    logic [PTR_W-1:0]  r_free_head;
    logic [PTR_W-1:0]  n_free_head;
    logic [PTR_W-1:0]  r_fresh;
    logic [PTR_W-1:0]  n_fresh;
    logic [QUEUES-1:0] r_qvalid;
    logic [QUEUES-1:0] n_qvalid;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [IO_W-1:0]   r_out_data;

    logic [QX_W-1:0]   q_live_ext;
    logic [QX_W-1:0]   q_ext;
    logic [QA_W-1:0]   q_idx;
    logic [QA_W-1:0]   q_raddr;
    logic              q_in_range;
    logic              q_busy;

    logic [SA_W-1:0]   head_rdata;
    logic [SA_W-1:0]   tail_rdata;
    logic [PTR_W-1:0]  link_rdata;
    logic [DATA_WIDTH-1:0] word_rdata;

    logic [SA_W-1:0]   slot;
    logic [SA_W-1:0]   link_raddr;
    logic [EXT_W-1:0]  word_in_ext;
    logic [EXT_W-1:0]  word_out_ext;

    logic              enq_ok;
    logic              deq_ok;
    logic              last_one;

    logic              link_we;
    logic [SA_W-1:0]   link_waddr;
    logic              head_we;
    logic [SA_W-1:0]   head_wdata;
    logic              tail_we;
    logic              word_we;

    logic [1:0]        res_status;
    logic [IO_W-1:0]   res_data;

    assign q_live_ext = QX_W'(i_queue_id);
    assign q_ext      = QX_W'(r_q);
    assign q_idx      = q_ext[QA_W-1:0];
    assign q_raddr    = i_cmd.sel_live ? q_live_ext[QA_W-1:0] : q_idx;
    assign q_in_range = ({1'b0, q_ext} < (QX_W+1)'(QUEUES));
    assign q_busy     = q_in_range && r_qvalid[q_idx];

    assign slot       = r_free_head[SA_W-1:0];
    assign link_raddr = (r_kind == KIND_DEQ) ? head_rdata : slot;

    assign enq_ok   = (r_kind == KIND_ENQ) && q_in_range && (r_free_head != NIL_PTR);
    assign deq_ok   = (r_kind == KIND_DEQ) && q_busy;
    assign last_one = (head_rdata == tail_rdata);

    assign word_in_ext  = EXT_W'(r_data);
    assign word_out_ext = EXT_W'(word_rdata);

    always_comb begin
        link_we     = 1'b0;
        link_waddr  = head_rdata;
        head_we     = 1'b0;
        head_wdata  = slot;
        tail_we     = 1'b0;
        word_we     = 1'b0;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_qvalid    = r_qvalid;
        res_status  = ST_OK;
        res_data    = '0;
        if (r_kind == KIND_ENQ) begin
            if (!enq_ok) begin
                res_status = ST_OVER;
            end else begin
                tail_we = 1'b1;
                word_we = 1'b1;
                if (q_busy) begin
                    link_we    = 1'b1;
                    link_waddr = tail_rdata;
                end else begin
                    head_we         = 1'b1;
                    n_qvalid[q_idx] = 1'b1;
                end
                if (r_free_head == r_fresh) begin
                    n_fresh     = r_fresh + PTR_W'(1);
                    n_free_head = r_fresh + PTR_W'(1);
                end else begin
                    n_free_head = link_rdata;
                end
            end
        end else begin
            if (!deq_ok) begin
                res_status = ST_UNDER;
                res_data   = '1;
            end else begin
                res_data    = word_out_ext[IO_W-1:0];
                link_we     = 1'b1;
                n_free_head = PTR_W'(head_rdata);
                if (last_one) begin
                    n_qvalid[q_idx] = 1'b0;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = link_rdata[SA_W-1:0];
                end
            end
        end
    end

    sbmq_ram #(.WIDTH(SA_W), .DEPTH(QUEUES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && head_we),
        .i_waddr (q_idx),
        .i_wdata (head_wdata),
        .i_raddr (q_raddr),
        .o_rdata (head_rdata)
    );

    sbmq_ram #(.WIDTH(SA_W), .DEPTH(QUEUES)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && tail_we),
        .i_waddr (q_idx),
        .i_wdata (slot),
        .i_raddr (q_raddr),
        .o_rdata (tail_rdata)
    );

    sbmq_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && link_we),
        .i_waddr (link_waddr),
        .i_wdata (r_free_head),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && word_we),
        .i_waddr (slot),
        .i_wdata (word_in_ext[DATA_WIDTH-1:0]),
        .i_raddr (head_rdata),
        .o_rdata (word_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_kind <= i_kind;
            r_q    <= i_queue_id;
            r_data <= i_data_in;
        end
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_data   <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fresh     <= '0;
            r_qvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_head <= n_free_head;
                r_fresh     <= n_fresh;
                r_qvalid    <= n_qvalid;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_data_out     = r_out_data;

endmodule
`default_nettype wire

>>> test/tb.sv
// self-checking testbench for the shared buffer multi queue unit
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbmq_pkg::*;

    localparam int RANDOM_OPS = 650;
    localparam int CALM_TAIL  = 80;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 20;

    typedef struct packed {
        logic             kind;
        logic [QIN_W-1:0] qid;
        logic [IO_W-1:0]  word;
    } t_queue_op;

    typedef struct packed {
        logic [1:0]      status;
        logic [IO_W-1:0] word;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // data_in
    logic [2:0]        s_axis_tuser = '0;   // kind, queue_id
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // data_out
    logic [1:0]        m_axis_tuser;        // status

    t_queue_op         op_backlog[$];
    t_reply            due_replies[$];
    t_queue_op         next_op;
    t_reply            want;

    logic [IO_W-1:0]   slot_word[SLOTS];
    logic [PTR_W-1:0]  slot_next[SLOTS];
    logic [PTR_W-1:0]  q_head[QUEUES];
    logic [PTR_W-1:0]  q_tail[QUEUES];
    logic [PTR_W-1:0]  free_slot;

    int                mismatches = 0;
    int                cycles = 0;
    int                src_hold = 0;
    int                snk_hold = 0;
    int                src_idle_pct = 0;
    int                snk_idle_pct = 0;
    int                n_enq = 0;
    int                n_deq = 0;
    int                n_over = 0;
    int                n_under = 0;

    shared_buffer_multi_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reply apply_queue_op(input logic kind, input logic [QIN_W-1:0] qid,
                                              input logic [IO_W-1:0] word);
        t_reply           r;
        logic [PTR_W-1:0] slot;
        r.status = ST_OK;
        r.word   = '0;
        if (kind == KIND_ENQ) begin
            if (qid >= QUEUES || free_slot >= SLOTS) begin
                r.status = ST_OVER;
            end else begin
                slot      = free_slot;
                free_slot = slot_next[slot];
                if (q_head[qid] >= SLOTS) begin
                    q_head[qid] = slot;
                end else if (q_tail[qid] < SLOTS) begin
                    slot_next[q_tail[qid]] = slot;
                end
                slot_next[slot] = NIL_PTR;
                q_tail[qid]     = slot;
                slot_word[slot] = word;
            end
        end else if (qid >= QUEUES || q_head[qid] >= SLOTS) begin
            r.status = ST_UNDER;
            r.word   = '1;
        end else begin
            slot            = q_head[qid];
            q_head[qid]     = slot_next[slot];
            slot_next[slot] = free_slot;
            free_slot       = slot;
            r.word          = slot_word[slot];
        end
        return r;
    endfunction

    task automatic push_op(input logic kind, input int qid, input logic [IO_W-1:0] word);
        t_queue_op op;
        op.kind = kind;
        op.qid  = qid[QIN_W-1:0];
        op.word = word;
        op_backlog.push_back(op);
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic logic [IO_W-1:0] pick_word();
        logic [IO_W-1:0] w;
        if ($urandom_range(0, 7) != 0) begin
            w = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: w = 32'h0000_0000;
                1: w = 32'hFFFF_FFFF;
                2: w = 32'h8000_0000;
                default: w = 32'h7FFF_FFFF;
            endcase
        end
        return w;
    endfunction

    // cycle limit and idle rate changes
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 128 == 0) begin
            case ($urandom_range(0, 2))
                0: src_idle_pct <= 0;
                1: src_idle_pct <= 15;
                default: src_idle_pct <= 40;
            endcase
            case ($urandom_range(0, 2))
                0: snk_idle_pct <= 0;
                1: snk_idle_pct <= 15;
                default: snk_idle_pct <= 40;
            endcase
        end
        if (cycles == CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_hold != 0) begin
                src_hold      <= src_hold - 1;
                s_axis_tvalid <= 1'b0;
            end else if (op_backlog.size() > CALM_TAIL &&
                         $urandom_range(0, 99) < src_idle_pct) begin
                src_hold      <= $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end else if (op_backlog.size() != 0) begin
                next_op       = op_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_op.word;
                s_axis_tuser  <= {next_op.qid, next_op.kind};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_hold != 0) begin
            snk_hold      <= snk_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (op_backlog.size() > CALM_TAIL &&
                     $urandom_range(0, 99) < snk_idle_pct) begin
            snk_hold      <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result check, then prediction of the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_replies.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result status %0d data %h",
                                            m_axis_tuser, m_axis_tdata));
                end else begin
                    want = due_replies.pop_front();
                    if (m_axis_tuser !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                m_axis_tuser, want.status));
                    if (m_axis_tdata !== want.word)
                        flag_mismatch($sformatf("data %h, expected %h",
                                                m_axis_tdata, want.word));
                    if (want.status == ST_OVER) n_over++;
                    if (want.status == ST_UNDER) n_under++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == KIND_ENQ) n_enq++;
                else n_deq++;
                due_replies.push_back(apply_queue_op(s_axis_tuser[0], s_axis_tuser[2:1],
                                                     s_axis_tdata));
            end
        end
    end

    initial begin
        int glen;
        int enq_pct;
        int focus;
        int qid;
        int total;
        for (int k = 0; k < SLOTS; k++) begin
            slot_word[k] = '0;
            slot_next[k] = (k == SLOTS - 1) ? NIL_PTR : PTR_W'(k + 1);
        end
        for (int k = 0; k < QUEUES; k++) begin
            q_head[k] = NIL_PTR;
            q_tail[k] = NIL_PTR;
        end
        free_slot = '0;

        // every queue empty after reset
        for (int k = 0; k < QUEUES; k++) push_op(KIND_DEQ, k, $urandom);
        // fill the whole memory, word extremes first
        push_op(KIND_ENQ, 0, 32'h8000_0000);
        push_op(KIND_ENQ, 0, 32'h7FFF_FFFF);
        push_op(KIND_ENQ, 1, 32'hFFFF_FFFF);
        push_op(KIND_ENQ, 1, 32'h0000_0000);
        for (int k = 0; k < SLOTS - 4; k++) push_op(KIND_ENQ, 1 + k % 3, $urandom);
        // no free slot left
        push_op(KIND_ENQ, 2, $urandom);
        // drain queue 0, then reuse it with a stale tail
        push_op(KIND_DEQ, 0, $urandom);
        push_op(KIND_DEQ, 0, $urandom);
        push_op(KIND_ENQ, 0, 32'h5555_AAAA);

        total = 0;
        while (total < RANDOM_OPS) begin
            glen = $urandom_range(16, 64);
            case ($urandom_range(0, 2))
                0: enq_pct = 15;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            focus = $urandom_range(0, QUEUES);
            repeat (glen) begin
                if (focus == QUEUES || $urandom_range(0, 3) == 0) qid = $urandom_range(0, 3);
                else qid = focus;
                push_op(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ, qid,
                        pick_word());
                total++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d requests: %0d enqueues, %0d dequeues", n_enq + n_deq, n_enq, n_deq);
        $display("%0d overflow and %0d underflow replies checked, %0d mismatches",
                 n_over, n_under, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
sv/sbmq_pkg.sv
sv/sbmq_ram.sv
sv/sbmq_ctrl.sv
sv/sbmq_dp.sv
sv/shared_buffer_multi_queue_unit.sv
test/tb.sv
